// ===== design/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is active
`define UBD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is active
`define UBD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/ubd_pkg.sv =====
// types, constants and codes of the blockage debounce core
package ubd_pkg;

    localparam int NUM_SENSORS = 16;

    localparam int IDX_W     = 4;
    localparam int RING_W    = 16;
    localparam int ETYPE_W   = 3;
    localparam int CNT_W     = 8;
    localparam int LIMIT_W   = 8;
    localparam int THR_W     = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    // memory holds at most as many entries as the index can address
    localparam int MEM_DEPTH = (NUM_SENSORS < (1 << IDX_W)) ? NUM_SENSORS : (1 << IDX_W);
    localparam int MEM_AW    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
    localparam int RANGE_W   = IDX_W + 2;

    // stream packing
    localparam int IN_FIELDS_W  = IDX_W + 1 + 1 + ETYPE_W + RING_W;
    localparam int IN_W         = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = 2 + IDX_W + CNT_W + CNT_W;
    localparam int OUT_W        = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_PAD_W    = OUT_W - OUT_FIELDS_W;

    typedef enum logic [1:0] {
        ACT_NONE  = 2'd0,
        ACT_SET   = 2'd1,
        ACT_CLEAR = 2'd2
    } ubd_action_t;

    typedef enum logic [ETYPE_W-1:0] {
        ECHO_FIXED      = 3'd0,
        ECHO_CHIRP_UP   = 3'd1,
        ECHO_CHIRP_DOWN = 3'd2,
        ECHO_NFD        = 3'd3
    } ubd_echo_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PDC_FIXED_LOW = 3'd0,
        REG_PDC_CHIRP_LOW = 3'd1,
        REG_PSM_FIXED_LOW = 3'd2,
        REG_PSM_CHIRP_LOW = 3'd3,
        REG_SET_LIMIT     = 3'd4,
        REG_CLEAR_LIMIT   = 3'd5
    } ubd_reg_t;

    localparam logic [THR_W-1:0]   PDC_FIXED_LOW_RST = 16'd912;
    localparam logic [THR_W-1:0]   PDC_CHIRP_LOW_RST = 16'd1840;
    localparam logic [THR_W-1:0]   PSM_FIXED_LOW_RST = 16'd1072;
    localparam logic [THR_W-1:0]   PSM_CHIRP_LOW_RST = 16'd1820;
    localparam logic [LIMIT_W-1:0] SET_LIMIT_RST     = 8'd22;
    localparam logic [LIMIT_W-1:0] CLEAR_LIMIT_RST   = 8'd45;

    typedef struct packed {
        logic [THR_W-1:0]   pdc_fixed_low;
        logic [THR_W-1:0]   pdc_chirp_low;
        logic [THR_W-1:0]   psm_fixed_low;
        logic [THR_W-1:0]   psm_chirp_low;
        logic [LIMIT_W-1:0] set_limit;
        logic [LIMIT_W-1:0] clear_limit;
    } ubd_cfg_t;

    typedef struct packed {
        logic [CNT_W-1:0] blk;
        logic [CNT_W-1:0] clr;
    } ubd_counts_t;

    typedef struct packed {
        logic [IDX_W-1:0]   idx;
        logic               fired;
        logic               stype;
        logic [ETYPE_W-1:0] etype;
        logic [RING_W-1:0]  ring;
    } ubd_item_t;

    typedef struct packed {
        logic        wr_en;
        ubd_action_t action;
        ubd_counts_t counts;
    } ubd_update_t;

endpackage

// ===== design/ubd_count_mem.sv =====
// per-sensor counter memory with registered read and reset-cleared valid bits
module ubd_count_mem
    import ubd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [MEM_AW-1:0] rd_addr,
    output ubd_counts_t       rd_data,
    input  logic              wr_en,
    input  logic [MEM_AW-1:0] wr_addr,
    input  ubd_counts_t       wr_data
);

    ubd_counts_t            mem [MEM_DEPTH];
    logic [MEM_DEPTH-1:0]   vld_reg;
    ubd_counts_t            rd_data_reg;
    logic                   rd_vld_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // an entry never written reads as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                vld_reg[wr_addr] <= 1'b1;
            end
            rd_vld_reg <= vld_reg[rd_addr];
        end
    end

    assign rd_data = rd_vld_reg ? rd_data_reg : '0;

endmodule

// ===== design/ubd_update.sv =====
// debounce step: threshold select, counter update and fault decision
module ubd_update
    import ubd_pkg::*;
(
    input  ubd_item_t   item,
    input  logic        in_range,
    input  ubd_counts_t cur,
    input  ubd_cfg_t    cfg,
    output ubd_update_t upd
);

    logic             valid_echo;
    logic             skip;
    logic             chirp;
    logic [THR_W-1:0] low;
    logic [CNT_W-1:0] blk_inc;
    logic [CNT_W-1:0] clr_inc;

    always_comb
    begin
        valid_echo = item.etype inside {ECHO_FIXED, ECHO_CHIRP_UP, ECHO_CHIRP_DOWN};
        skip       = !item.fired || (item.ring == '0) || !valid_echo;
        chirp      = (item.etype != ECHO_FIXED);

        case (item.stype)
            1'b0:    low = chirp ? cfg.pdc_chirp_low : cfg.pdc_fixed_low;
            1'b1:    low = chirp ? cfg.psm_chirp_low : cfg.psm_fixed_low;
            default: low = cfg.pdc_fixed_low;
        endcase

        blk_inc = (cur.blk == '1) ? cur.blk : cur.blk + 1'b1;
        clr_inc = (cur.clr == '1) ? cur.clr : cur.clr + 1'b1;

        upd.wr_en  = in_range && !skip;
        upd.action = ACT_NONE;
        upd.counts = cur;

        if (!in_range)
        begin
            upd.counts = '0;
        end
        else if (!skip)
        begin
            if (item.ring < low)
            begin
                upd.counts.blk = blk_inc;
                if (blk_inc >= cfg.set_limit)
                begin
                    upd.counts.blk = cfg.set_limit;
                    upd.counts.clr = '0;
                    upd.action     = ACT_SET;
                end
            end
            else if (cur.blk != '0)
            begin
                upd.counts.clr = clr_inc;
                if (clr_inc >= cfg.clear_limit)
                begin
                    upd.counts = '0;
                    upd.action = ACT_CLEAR;
                end
            end
            else
            begin
                upd.action = ACT_CLEAR;
            end
        end
    end

endmodule

// ===== design/ubd_cfg_regs.sv =====
// configuration register file
module ubd_cfg_regs
    import ubd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr_en,
    input  logic [CFG_IDX_W-1:0]  wr_index,
    input  logic [CFG_DATA_W-1:0] wr_data,
    output ubd_cfg_t              cfg
);

    ubd_cfg_t cfg_reg;
    ubd_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (ubd_reg_t'(wr_index))
                REG_PDC_FIXED_LOW: cfg_next.pdc_fixed_low = wr_data[THR_W-1:0];
                REG_PDC_CHIRP_LOW: cfg_next.pdc_chirp_low = wr_data[THR_W-1:0];
                REG_PSM_FIXED_LOW: cfg_next.psm_fixed_low = wr_data[THR_W-1:0];
                REG_PSM_CHIRP_LOW: cfg_next.psm_chirp_low = wr_data[THR_W-1:0];
                REG_SET_LIMIT:     cfg_next.set_limit     = wr_data[LIMIT_W-1:0];
                REG_CLEAR_LIMIT:   cfg_next.clear_limit   = wr_data[LIMIT_W-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pdc_fixed_low <= PDC_FIXED_LOW_RST;
            cfg_reg.pdc_chirp_low <= PDC_CHIRP_LOW_RST;
            cfg_reg.psm_fixed_low <= PSM_FIXED_LOW_RST;
            cfg_reg.psm_chirp_low <= PSM_CHIRP_LOW_RST;
            cfg_reg.set_limit     <= SET_LIMIT_RST;
            cfg_reg.clear_limit   <= CLEAR_LIMIT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== design/ultrasonic_blockage_debounce_core.sv =====
// top level of the ultrasonic blockage debounce core
// Each input beat is one ultrasonic measurement; each one gives exactly one
// output beat with the fault action (none, set, clear) and the sensor's
// blockage and clear counters after the step. The core sustains one beat per
// clock while the output is not stalled: a beat is taken, the per-sensor
// counters are read from a synchronous memory, and the update is then computed,
// written back and registered on the output once the output register is free.
// Back-to-back beats for the same sensor are served by a forwarding register
// that holds the entry written last. Counters read as zero after reset
// (per-entry valid bits, no clearing pass). Configuration writes are always
// accepted and should only be issued while no beat is in flight.
module ultrasonic_blockage_debounce_core
    import ubd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // input stream, tdata from bit 0: sensor_num[3:0], fired_and_answered,
    // sensor_type, echo_type[2:0], ring_time_us[15:0], zero pad
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_W-1:0]       s_axis_tdata,
    // output stream, tdata from bit 0: fault_action[1:0], sensor_out[3:0],
    // block_count_out[7:0], clear_count_out[7:0], zero pad
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_W-1:0]      m_axis_tdata,
    // configuration write channel
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    ubd_cfg_t    cfg;
    ubd_item_t   in_unpacked;

    // read stage
    logic        s1_valid_reg;
    logic        s1_valid_next;
    ubd_item_t   s1_item_reg;
    logic        s1_advance;

    // forwarding of the entry written last, always coherent with the memory
    logic              fwd_valid_reg;
    logic [MEM_AW-1:0] fwd_addr_reg;
    ubd_counts_t       fwd_counts_reg;

    logic [MEM_AW-1:0] rd_addr;
    ubd_counts_t       mem_rd_data;
    ubd_counts_t       cur_counts;
    logic [MEM_AW-1:0] s1_addr;
    logic              s1_in_range;
    logic              wr_en;
    ubd_update_t       upd;

    // output register
    logic              out_valid_reg;
    logic [OUT_W-1:0]  out_data_reg;

    assign cfg_ready = 1'b1;

    ubd_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // unpack the input beat
    // note: struct field order is msb first, so unpack explicitly
    always_comb
    begin
        in_unpacked.idx   = s_axis_tdata[IDX_W-1:0];
        in_unpacked.fired = s_axis_tdata[IDX_W];
        in_unpacked.stype = s_axis_tdata[IDX_W+1];
        in_unpacked.etype = s_axis_tdata[IDX_W+2 +: ETYPE_W];
        in_unpacked.ring  = s_axis_tdata[IDX_W+2+ETYPE_W +: RING_W];
    end

    // the read stage moves on when the output register is free or being drained
    assign s1_advance    = s1_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !s1_valid_reg || s1_advance;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (s_axis_tready)
        begin
            s1_valid_next = s_axis_tvalid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            s1_item_reg <= in_unpacked;
        end
    end

    // a held item re-reads its own entry so the read data stays current
    assign rd_addr = s_axis_tready ? in_unpacked.idx[MEM_AW-1:0]
                                   : s1_item_reg.idx[MEM_AW-1:0];

    ubd_count_mem u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_addr (rd_addr),
        .rd_data (mem_rd_data),
        .wr_en   (wr_en),
        .wr_addr (s1_addr),
        .wr_data (upd.counts)
    );

    assign s1_addr     = s1_item_reg.idx[MEM_AW-1:0];
    assign s1_in_range = RANGE_W'(s1_item_reg.idx) < RANGE_W'(NUM_SENSORS);

    // a write in the cycle of the read is not seen by the memory output yet
    assign cur_counts = (fwd_valid_reg && (fwd_addr_reg == s1_addr)) ? fwd_counts_reg
                                                                     : mem_rd_data;

    ubd_update u_upd (
        .item     (s1_item_reg),
        .in_range (s1_in_range),
        .cur      (cur_counts),
        .cfg      (cfg),
        .upd      (upd)
    );

    assign wr_en = s1_advance && upd.wr_en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_valid_reg <= 1'b0;
        end
        else if (wr_en)
        begin
            fwd_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            fwd_addr_reg   <= s1_addr;
            fwd_counts_reg <= upd.counts;
        end
    end

    // output register, filled from the read stage, drained by the sink
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance)
        begin
            out_data_reg <= {{OUT_PAD_W{1'b0}}, upd.counts.clr, upd.counts.blk,
                             s1_item_reg.idx, upd.action};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

// ===== design/ubd_port_checker.sv =====
// port-level checker of the blockage debounce core and its bind
`include "assert_macros.svh"

module ubd_port_checker
    import ubd_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_W-1:0]      m_axis_tdata
);

    logic [1:0]       act;
    logic [CNT_W-1:0] blk;
    logic [CNT_W-1:0] clr;

    assign act = m_axis_tdata[1:0];
    assign blk = m_axis_tdata[2+IDX_W +: CNT_W];
    assign clr = m_axis_tdata[2+IDX_W+CNT_W +: CNT_W];

    // a stalled output beat stays up with the same data
    `UBD_ASSERT_NEXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "output beat dropped while stalled")
    `UBD_ASSERT_NEXT(a_out_stable, clk, rst_n, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata), "output data changed while stalled")
    // clear counter only runs while a blockage is being counted
    `UBD_ASSERT_IMP(a_clr_needs_blk, clk, rst_n, m_axis_tvalid, !((blk == '0) && (clr != '0)), "clear count without blockage count")
    // a clear action leaves both counters at zero
    `UBD_ASSERT_IMP(a_clear_zero, clk, rst_n, m_axis_tvalid && (act == ACT_CLEAR), (blk == '0) && (clr == '0), "counters not zero after clear")

endmodule

bind ultrasonic_blockage_debounce_core ubd_port_checker u_ubd_port_checker (.*);
